// ===== src/ftpp_pkg.sv =====
// Shared constants for the file transfer packet parser.
`default_nettype none
package ftpp_pkg;
    localparam int unsigned MAX_SIZE_BYTES = 4;
    localparam int unsigned COUNT_W        = 17;
    localparam int unsigned SIZE_LEFT_W    = $clog2(MAX_SIZE_BYTES + 1);

    localparam logic [7:0]         TYPE_DATA      = 8'h01;
    localparam logic [7:0]         TAG_SIZE       = 8'h00;
    localparam logic [7:0]         TAG_NAME       = 8'h01;
    localparam logic [COUNT_W-1:0] DATA_MIN_BYTES = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] CTRL_MIN_BYTES = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};

    localparam logic [2:0] ERR_OK         = 3'd0;
    localparam logic [2:0] ERR_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ERR_SIZE_TAG   = 3'd2;
    localparam logic [2:0] ERR_SIZE_CUT   = 3'd3;
    localparam logic [2:0] ERR_NAME_TAG   = 3'd4;
    localparam logic [2:0] ERR_NAME_CUT   = 3'd5;
    localparam logic [2:0] ERR_SIZE_LONG  = 3'd6;
endpackage
`default_nettype wire

// ===== src/file_transfer_packet_parser_unit.sv =====
// Byte-serial parser for file transfer data and control packets.
//
// Takes one packet byte per item, with i_end_of_packet on the last byte, and
// accepts a new byte every cycle unless a result item waits on i_out_ready.
// Each byte is parsed in the cycle it is accepted and its result item, if
// any, is registered on the next cycle by the single parse stage between
// the packet state registers and the output register. Data payload and file
// name bytes come out as they arrive; the last byte of a packet also carries
// the packet summary and an error code. Bytes that give no result (headers,
// tags, size bytes, ignored trailing bytes) are consumed silently.
`default_nettype none
module file_transfer_packet_parser_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic                  i_end_of_packet,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_payload_valid,
    output logic [7:0]                 o_payload_byte,
    output logic                       o_payload_is_name,
    output logic                       o_packet_done,
    output logic [7:0]                 o_packet_type,
    output logic [7:0]                 o_sequence_res,
    output logic [15:0]                o_data_length,
    output logic [31:0]                o_file_size,
    output logic [7:0]                 o_name_length,
    output logic [2:0]                 o_error_code
);
    import ftpp_pkg::*;

    typedef enum logic [3:0] {
        PH_FIRST, PH_D_SEQ, PH_D_LHI, PH_D_LLO, PH_D_PAY,
        PH_C_STAG, PH_C_SLEN, PH_C_SVAL, PH_C_NTAG, PH_C_NLEN, PH_C_NVAL, PH_SKIP
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [COUNT_W-1:0]     r_count, n_count, c_count, inc_count;
    logic [7:0]             r_type, n_type;
    logic [7:0]             r_seq, n_seq;
    logic [15:0]            r_length, n_length;
    logic [31:0]            r_size, n_size;
    logic [SIZE_LEFT_W-1:0] r_size_left, n_size_left;
    logic [7:0]             r_name_len, n_name_len;
    logic [7:0]             r_name_left, n_name_left;
    logic [2:0]             r_error, n_error;

    logic       pv, pn, accept, is_data, has_result;
    logic [1:0] lane;
    logic [2:0] fin_error;

    assign o_in_ready = !o_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign lane       = c_count[1:0] + 2'd1;

    always_comb begin
        if (r_phase == PH_FIRST) begin
            c_count     = '0;
            n_type      = '0;
            n_seq       = '0;
            n_length    = '0;
            n_size      = '0;
            n_size_left = '0;
            n_name_len  = '0;
            n_name_left = '0;
            n_error     = ERR_OK;
        end else begin
            c_count     = r_count;
            n_type      = r_type;
            n_seq       = r_seq;
            n_length    = r_length;
            n_size      = r_size;
            n_size_left = r_size_left;
            n_name_len  = r_name_len;
            n_name_left = r_name_left;
            n_error     = r_error;
        end
        inc_count = (c_count != COUNT_MAX) ? c_count + COUNT_W'(1) : c_count;
        n_phase   = r_phase;
        pv        = 1'b0;
        pn        = 1'b0;

        case (r_phase)
            PH_FIRST: begin
                n_type  = i_rx_byte;
                n_phase = (i_rx_byte == TYPE_DATA) ? PH_D_SEQ : PH_C_STAG;
            end
            PH_D_SEQ: begin
                n_seq   = i_rx_byte;
                n_phase = PH_D_LHI;
            end
            PH_D_LHI: begin
                n_length = {i_rx_byte, 8'h00};
                n_phase  = PH_D_LLO;
            end
            PH_D_LLO: begin
                n_length = {n_length[15:8], i_rx_byte};
                n_phase  = PH_D_PAY;
            end
            PH_D_PAY: begin
                pv = (c_count - DATA_MIN_BYTES) < COUNT_W'(n_length);
            end
            PH_C_STAG: begin
                if (i_rx_byte != TAG_SIZE) begin
                    n_error = ERR_SIZE_TAG;
                    n_phase = PH_SKIP;
                end else begin
                    n_phase = PH_C_SLEN;
                end
            end
            PH_C_SLEN: begin
                if (i_rx_byte > 8'(MAX_SIZE_BYTES)) begin
                    n_error = ERR_SIZE_LONG;
                    n_phase = PH_SKIP;
                end else begin
                    n_size_left = SIZE_LEFT_W'(i_rx_byte);
                    n_phase     = (i_rx_byte != 8'h00) ? PH_C_SVAL : PH_C_NTAG;
                end
            end
            PH_C_SVAL: begin
                n_size      = n_size | ({24'h000000, i_rx_byte} << {lane, 3'b000});
                n_size_left = n_size_left - SIZE_LEFT_W'(1);
                if (n_size_left == '0) begin
                    n_phase = PH_C_NTAG;
                end
            end
            PH_C_NTAG: begin
                if (i_rx_byte != TAG_NAME) begin
                    n_error = ERR_NAME_TAG;
                    n_phase = PH_SKIP;
                end else begin
                    n_phase = PH_C_NLEN;
                end
            end
            PH_C_NLEN: begin
                n_name_len  = i_rx_byte;
                n_name_left = i_rx_byte;
                n_phase     = (i_rx_byte != 8'h00) ? PH_C_NVAL : PH_SKIP;
            end
            PH_C_NVAL: begin
                pv          = 1'b1;
                pn          = 1'b1;
                n_name_left = n_name_left - 8'd1;
                if (n_name_left == 8'd0) begin
                    n_phase = PH_SKIP;
                end
            end
            default: begin
            end
        endcase

        is_data = (n_type == TYPE_DATA);
        if (is_data) begin
            fin_error = (inc_count < DATA_MIN_BYTES) ? ERR_TOO_SHORT : ERR_OK;
        end else if (inc_count < CTRL_MIN_BYTES) begin
            fin_error = ERR_TOO_SHORT;
        end else if (n_error != ERR_OK) begin
            fin_error = n_error;
        end else begin
            case (n_phase)
                PH_C_SVAL: fin_error = ERR_SIZE_CUT;
                PH_C_NTAG: fin_error = ERR_NAME_TAG;
                PH_C_NLEN: fin_error = ERR_NAME_CUT;
                PH_C_NVAL: fin_error = (n_name_left != 8'd0) ? ERR_NAME_CUT : ERR_OK;
                default:   fin_error = ERR_OK;
            endcase
        end

        n_count = inc_count;
        if (i_end_of_packet) begin
            n_phase = PH_FIRST;
            n_count = '0;
        end
        has_result = pv || i_end_of_packet;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_FIRST;
            r_count           <= '0;
            r_type            <= '0;
            r_seq             <= '0;
            r_length          <= '0;
            r_size            <= '0;
            r_size_left       <= '0;
            r_name_len        <= '0;
            r_name_left       <= '0;
            r_error           <= ERR_OK;
            o_out_valid       <= 1'b0;
            o_payload_valid   <= 1'b0;
            o_payload_byte    <= 8'h00;
            o_payload_is_name <= 1'b0;
            o_packet_done     <= 1'b0;
            o_packet_type     <= 8'h00;
            o_sequence_res    <= 8'h00;
            o_data_length     <= 16'h0000;
            o_file_size       <= 32'h0;
            o_name_length     <= 8'h00;
            o_error_code      <= ERR_OK;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_type      <= n_type;
                r_seq       <= n_seq;
                r_length    <= n_length;
                r_size      <= n_size;
                r_size_left <= n_size_left;
                r_name_len  <= n_name_len;
                r_name_left <= n_name_left;
                r_error     <= n_error;
                o_out_valid <= has_result;
                // result payload, loaded on every accepted item
                o_payload_valid   <= pv;
                o_payload_byte    <= pv ? i_rx_byte : 8'h00;
                o_payload_is_name <= pn;
                o_packet_done     <= i_end_of_packet;
                o_packet_type     <= i_end_of_packet ? n_type : 8'h00;
                o_sequence_res    <= (i_end_of_packet && is_data) ? n_seq : 8'h00;
                o_data_length     <= (i_end_of_packet && is_data) ? n_length : 16'h0000;
                o_file_size       <= (i_end_of_packet && !is_data) ? n_size : 32'h0;
                o_name_length     <= (i_end_of_packet && !is_data) ? n_name_len : 8'h00;
                o_error_code      <= i_end_of_packet ? fin_error : ERR_OK;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_idle_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_packet_done |-> o_packet_type == 8'h00 && o_error_code == ERR_OK)
        else $error("summary fields set without packet end");
    a_name_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_is_name |-> o_payload_valid)
        else $error("name flag without payload byte");
    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_payload_valid || o_packet_done)
        else $error("empty result item");
    a_data_no_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_done && o_packet_type == TYPE_DATA
            |-> o_file_size == 32'h0 && o_name_length == 8'h00 && o_error_code != ERR_SIZE_TAG)
        else $error("control fields on data packet");
`endif
endmodule
`default_nettype wire
